// ===== hw/rtl/rst_pkg.sv =====
package rst_pkg;

  // fixed field widths
  localparam int POS_W   = 16;
  localparam int DELTA_W = 2;
  localparam int SUM_W   = 32;

  // operation codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_U_READ,
    ST_U_LEAF,
    ST_U_UP,
    ST_Q_LEFT,
    ST_Q_RIGHT,
    ST_Q_FIN
  } state_t;

endpackage

// ===== hw/rtl/rst_if.sv =====
// request channel
interface rst_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic        [rst_pkg::POS_W-1:0]    position;
  logic signed [rst_pkg::DELTA_W-1:0]  delta;
  logic        [rst_pkg::POS_W-1:0]    range_low;
  logic        [rst_pkg::POS_W-1:0]    range_high;

  modport source (output valid, output operation, output position, output delta,
                  output range_low, output range_high, input ready);
  modport sink   (input valid, input operation, input position, input delta,
                  input range_low, input range_high, output ready);
endinterface

// result channel
interface rst_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rst_pkg::SUM_W-1:0]  range_sum;

  modport source (output valid, output range_sum, input ready);
  modport sink   (input valid, input range_sum, output ready);
endinterface

// ===== hw/rtl/rst_node_ram.sv =====
module rst_node_ram #(
  parameter int AW = 17
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [rst_pkg::SUM_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [rst_pkg::SUM_W-1:0] rd_data
);

  logic [rst_pkg::SUM_W-1:0] mem [(1 << AW)];
  logic [rst_pkg::SUM_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/range_sum_tree_unit.sv =====
// Sum tree over LEAVES leaves, kept heap ordered in one node memory
// (node 1 is the root, leaf i sits at node LEAVES + i).
// in_req carries one request: operation 0 adds delta to leaf position and
// refreshes every ancestor, operation 1 asks for the wrapped 32-bit sum of
// leaves range_low..range_high. A query yields one result on out_res; an
// update yields none. Empty or out-of-range queries return 0, updates past
// the last leaf are dropped.
// Timing is set by the single read port of the node memory: an update reads
// the leaf, writes it back and then writes one ancestor per level; a query
// walks up the levels with a left and a right boundary step on each level
// and then hands over its sum. One request is worked on at a time.
// After reset a clearing pass writes zero to all 2 * LEAVES nodes, one per
// cycle, while in_req.ready stays low.
// The result sits in an output register: while the receiver stalls, the block
// still takes and runs the next request and only waits before it would
// overwrite a result not yet taken.
module range_sum_tree_unit #(
  parameter int LEAVES = 65536
) (
  input  logic         clk,
  input  logic         rst_n,
  rst_in_if.sink       in_req,
  rst_out_if.source    out_res
);

  localparam int LW = $clog2(LEAVES);
  localparam int NW = LW + 1;
  localparam int XW = (LW > rst_pkg::POS_W) ? LW : rst_pkg::POS_W;
  localparam int SW = rst_pkg::SUM_W;

  rst_pkg::state_t state_r, state_nxt;

  logic [NW-1:0]              node_r, node_nxt;
  logic [NW:0]                l_r, l_nxt;
  logic [NW:0]                r_r, r_nxt;
  logic signed [rst_pkg::DELTA_W-1:0] delta_r, delta_nxt;
  logic [SW-1:0]              cur_r, cur_nxt;
  logic [SW-1:0]              acc_r, acc_nxt;
  logic                       pend_r, pend_nxt;
  logic [NW-1:0]              clr_r, clr_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [SW-1:0]              out_sum_r, out_sum_nxt;

  logic                       wr_en;
  logic [NW-1:0]              wr_addr;
  logic [SW-1:0]              wr_data;
  logic                       rd_en;
  logic [NW-1:0]              rd_addr;
  logic [SW-1:0]              rd_data;

  logic                       in_fire;
  logic [XW:0]                pos_x, lo_x, hi_x;
  logic                       pos_ok, range_ok;
  logic [LW-1:0]              hi_sat;
  logic [NW:0]                l_start, r_start, r_dec;
  logic [NW-1:0]              parent;
  logic [SW-1:0]              leaf_new, up_sum;

  rst_node_ram #(.AW(NW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_req.ready      = (state_r == rst_pkg::ST_IDLE);
  assign in_fire           = in_req.valid && in_req.ready;
  assign out_res.valid     = out_valid_r;
  assign out_res.range_sum = out_sum_r;

  // request decode
  always_comb begin
    pos_x    = (XW + 1)'(in_req.position);
    lo_x     = (XW + 1)'(in_req.range_low);
    hi_x     = (XW + 1)'(in_req.range_high);
    pos_ok   = pos_x < (XW + 1)'(LEAVES);
    range_ok = (lo_x < (XW + 1)'(LEAVES)) && (in_req.range_low <= in_req.range_high);
    hi_sat   = (hi_x >= (XW + 1)'(LEAVES)) ? {LW{1'b1}} : hi_x[LW-1:0];
    l_start  = {1'b0, 1'b1, lo_x[LW-1:0]};
    r_start  = {1'b0, 1'b1, hi_sat} + (NW + 1)'(1);
  end

  // datapath helpers
  always_comb begin
    parent   = node_r >> 1;
    leaf_new = rd_data + SW'(delta_r);
    up_sum   = cur_r + rd_data;
    r_dec    = r_r - (NW + 1)'(1);
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    delta_nxt     = delta_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_r + (pend_r ? rd_data : '0);
    pend_nxt      = 1'b0;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_sum_nxt   = out_sum_r;
    wr_en         = 1'b0;
    wr_addr       = node_r;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = node_r;

    case (state_r)
      // zero every node after reset
      rst_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + NW'(1);
        if (clr_r == {NW{1'b1}}) begin
          state_nxt = rst_pkg::ST_IDLE;
        end
      end

      // take a request
      rst_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_req.operation == rst_pkg::OP_QUERY) begin
            acc_nxt   = '0;
            l_nxt     = range_ok ? l_start : '0;
            r_nxt     = range_ok ? r_start : '0;
            state_nxt = rst_pkg::ST_Q_LEFT;
          end else if (pos_ok) begin
            node_nxt  = {1'b1, pos_x[LW-1:0]};
            delta_nxt = in_req.delta;
            state_nxt = rst_pkg::ST_U_READ;
          end
        end
      end

      // fetch the leaf
      rst_pkg::ST_U_READ: begin
        rd_en     = 1'b1;
        rd_addr   = node_r;
        state_nxt = rst_pkg::ST_U_LEAF;
      end

      // write the leaf back, fetch its sibling
      rst_pkg::ST_U_LEAF: begin
        wr_en     = 1'b1;
        wr_addr   = node_r;
        wr_data   = leaf_new;
        cur_nxt   = leaf_new;
        rd_en     = 1'b1;
        rd_addr   = node_r ^ NW'(1);
        state_nxt = rst_pkg::ST_U_UP;
      end

      // one level up per cycle: parent = node + sibling
      rst_pkg::ST_U_UP: begin
        wr_en    = 1'b1;
        wr_addr  = parent;
        wr_data  = up_sum;
        cur_nxt  = up_sum;
        node_nxt = parent;
        if (parent == NW'(1)) begin
          state_nxt = rst_pkg::ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent ^ NW'(1);
        end
      end

      // left boundary of the current level
      rst_pkg::ST_Q_LEFT: begin
        if (l_r < r_r) begin
          if (l_r[0]) begin
            rd_en    = 1'b1;
            rd_addr  = l_r[NW-1:0];
            pend_nxt = 1'b1;
            l_nxt    = l_r + (NW + 1)'(1);
          end
          state_nxt = rst_pkg::ST_Q_RIGHT;
        end else begin
          state_nxt = rst_pkg::ST_Q_FIN;
        end
      end

      // right boundary, then move both up a level
      rst_pkg::ST_Q_RIGHT: begin
        if (r_r[0]) begin
          rd_en    = 1'b1;
          rd_addr  = r_dec[NW-1:0];
          pend_nxt = 1'b1;
          r_nxt    = r_dec >> 1;
        end else begin
          r_nxt    = r_r >> 1;
        end
        l_nxt     = l_r >> 1;
        state_nxt = rst_pkg::ST_Q_LEFT;
      end

      // hand the sum to the output register once it is free
      rst_pkg::ST_Q_FIN: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_r;
          state_nxt     = rst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rst_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rst_pkg::ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    delta_r   <= delta_nxt;
    cur_r     <= cur_nxt;
    acc_r     <= acc_nxt;
    out_sum_r <= out_sum_nxt;
  end

endmodule

// ===== hw/rtl/rst_checker.sv =====
module rst_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_operation,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rst_pkg::SUM_W-1:0] range_sum
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(range_sum))
    else $error("result changed while stalled");

  // reset starts the clearing pass, no request taken
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request port open right after reset");

  // a query keeps the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == rst_pkg::OP_QUERY) |=> !in_ready)
    else $error("request port open right after a query");

  // a result appears only at the end of a query walk
  a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a query in progress");

endmodule

bind range_sum_tree_unit rst_checker u_rst_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .in_operation (in_req.operation),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .range_sum    (out_res.range_sum)
);
